>>> rtl/amru_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and helper functions for the atomic memory rmw unit
// no dependencies

package amru_pkg;

    localparam int OP_W     = 3;
    localparam int SIZE_W   = 2;
    localparam int OFFS_W   = 16;
    localparam int DATA_W   = 64;
    localparam int LIMIT_W  = 13;
    localparam int EXT_W    = 17;
    localparam int LANES    = 8;
    localparam int LANE_W   = 3;
    localparam int IN_TDATA_W  = 152;
    localparam int OUT_TDATA_W = 72;
    localparam int CFG_IDX_W   = 1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD     = 3'd0,
        OP_STORE    = 3'd1,
        OP_EXCHANGE = 3'd2,
        OP_CMPXCHG  = 3'd3,
        OP_ADD      = 3'd4,
        OP_AND      = 3'd5,
        OP_OR       = 3'd6,
        OP_XOR      = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BOUNDS   = 2'd1,
        ST_READONLY = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIMIT    = 1'd0,
        CFG_WRITABLE = 1'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] old_value;
        logic              success;
        logic [DATA_W-1:0] wdata;
        logic [LANES-1:0]  wen;
    } t_alu_res;

    function automatic logic [DATA_W-1:0] size_mask(input logic [SIZE_W-1:0] size);
        logic [DATA_W-1:0] m;
        case (size)
            2'd0:    m = 64'h0000_0000_0000_00FF;
            2'd1:    m = 64'h0000_0000_0000_FFFF;
            2'd2:    m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [LANES-1:0] size_lanes(input logic [SIZE_W-1:0] size);
        logic [LANES-1:0] e;
        case (size)
            2'd0:    e = 8'h01;
            2'd1:    e = 8'h03;
            2'd2:    e = 8'h0F;
            default: e = 8'hFF;
        endcase
        return e;
    endfunction

endpackage

>>> rtl/atomic_memory_rmw_unit.sv
`timescale 1ns / 1ps
// top level of the atomic memory rmw unit: control, checks, banks and result register
// depends on amru_pkg, amru_bank_mem and amru_alu

// Atomic load, store, exchange, compare-exchange and fetch-add/and/or/xor on a
// little-endian byte store of MEM_BYTES bytes, 1, 2, 4 or 8 bytes at any byte
// offset. The store is split into eight byte banks with a registered read
// port, so an unaligned access reads and writes every byte in one pass. The
// banks are read in the cycle the request transfers; the execute state then
// modifies and writes back while the result is loaded into the output
// register, and the next request is taken only after that write, so no two
// accesses overlap. A request may transfer while the previous result still
// waits to be taken, but its write-back then waits until that result
// transfers. After reset the store is cleared one row of eight bytes a cycle,
// over all ceil(MEM_BYTES / 8) rows, during which no request is taken;
// configuration writes are taken at any time.

module atomic_memory_rmw_unit import amru_pkg::*; #(
    parameter int MEM_BYTES = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // op, size_code, offset, operand_value, desired_value, zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // old_value, exchange_success, status, zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [LIMIT_W-1:0]     i_cfg_wdata
);

    localparam int ROWS = (MEM_BYTES + LANES - 1) / LANES;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [RW-1:0]    LastRow   = RW'(ROWS - 1);
    localparam logic [EXT_W-1:0] MemBytesW = EXT_W'(MEM_BYTES);

    t_state r_state, n_state;

    logic [LIMIT_W-1:0] r_limit;
    logic               r_writable;
    logic [RW-1:0]      r_clr_row;

    t_op                r_op;
    logic [SIZE_W-1:0]  r_size;
    logic [LANE_W-1:0]  r_lane;
    logic [RW-1:0]      r_rows [LANES];
    logic [DATA_W-1:0]  r_operand;
    logic [DATA_W-1:0]  r_desired;
    t_status            r_status;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic in_xfer;
    logic clearing;
    logic exec_go;

    t_op               in_op;
    logic [SIZE_W-1:0] in_size;
    logic [OFFS_W-1:0] in_offs;
    logic [EXT_W-1:0]  in_end;
    logic [EXT_W-1:0]  limit_eff;
    t_status           in_status;
    logic [RW-1:0]     rd_rows [LANES];

    logic [DATA_W-1:0] bank_data;
    t_alu_res          alu_res;

    assign in_op   = t_op'(s_axis_tdata[2:0]);
    assign in_size = s_axis_tdata[4:3];
    assign in_offs = s_axis_tdata[20:5];

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= LIMIT_W'(4096);
            r_writable <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LIMIT:    r_limit    <= i_cfg_wdata;
                CFG_WRITABLE: r_writable <= i_cfg_wdata[0];
                default:      r_writable <= r_writable;
            endcase
        end
    end

    // state machine
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr_row == LastRow) n_state = S_IDLE;
            S_IDLE:  if (s_axis_tvalid) n_state = S_EXEC;
            S_EXEC:  if (!r_out_valid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        clearing      = 1'b0;
        exec_go       = 1'b0;
        case (r_state)
            S_CLEAR: clearing      = 1'b1;
            S_IDLE:  s_axis_tready = 1'b1;
            S_EXEC:  exec_go       = !r_out_valid || m_axis_tready;
            default: clearing      = 1'b0;
        endcase
    end

    assign in_xfer = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_row <= '0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr_row <= r_clr_row + RW'(1);
            end
        end
    end

    // checks and bank row selection at request transfer
    assign in_end    = {1'b0, in_offs} + (EXT_W'(1) << in_size);
    assign limit_eff = (EXT_W'(r_limit) > MemBytesW) ? MemBytesW : EXT_W'(r_limit);

    always_comb begin
        if (in_end > limit_eff) begin
            in_status = ST_BOUNDS;
        end else if (in_op != OP_LOAD && !r_writable) begin
            in_status = ST_READONLY;
        end else begin
            in_status = ST_OK;
        end
    end

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            rd_rows[j] = RW'({1'b0, in_offs[OFFS_W-1:LANE_W]}
                         + ((LANE_W'(j) < in_offs[LANE_W-1:0]) ? 14'd1 : 14'd0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op      <= in_op;
            r_size    <= in_size;
            r_lane    <= in_offs[LANE_W-1:0];
            r_operand <= s_axis_tdata[84:21];
            r_desired <= s_axis_tdata[148:85];
            r_status  <= in_status;
            for (int j = 0; j < LANES; j++) begin
                r_rows[j] <= rd_rows[j];
            end
        end
    end

    // byte banks
    for (genvar g = 0; g < LANES; g++) begin : g_bank
        logic          we;
        logic [RW-1:0] waddr;
        logic [7:0]    wdata;

        assign we    = clearing || (exec_go && alu_res.wen[g]);
        assign waddr = clearing ? r_clr_row : r_rows[g];
        assign wdata = clearing ? 8'h00 : alu_res.wdata[8*g +: 8];

        amru_bank_mem #(
            .DEPTH (ROWS),
            .AW    (RW)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (waddr),
            .i_wdata (wdata),
            .i_re    (in_xfer),
            .i_raddr (rd_rows[g]),
            .o_rdata (bank_data[8*g +: 8])
        );
    end

    amru_alu u_alu (
        .i_bank_data (bank_data),
        .i_lane      (r_lane),
        .i_size      (r_size),
        .i_op        (r_op),
        .i_ok        (r_status == ST_OK),
        .i_operand   (r_operand),
        .i_desired   (r_desired),
        .o_res       (alu_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_go) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_out_data <= {5'b0, r_status, alu_res.success, alu_res.old_value};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> rtl/amru_bank_mem.sv
`timescale 1ns / 1ps
// one byte-wide bank of the store, one write and one registered read port
// depends on nothing

module amru_bank_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

>>> rtl/amru_alu.sv
`timescale 1ns / 1ps
// aligns the read bank bytes, applies the atomic operation and builds bank writes
// depends on amru_pkg

module amru_alu import amru_pkg::*; (
    input  logic [DATA_W-1:0] i_bank_data,
    input  logic [LANE_W-1:0] i_lane,
    input  logic [SIZE_W-1:0] i_size,
    input  t_op               i_op,
    input  logic              i_ok,
    input  logic [DATA_W-1:0] i_operand,
    input  logic [DATA_W-1:0] i_desired,
    output t_alu_res          o_res
);

    logic [5:0]          shamt;
    logic [2*DATA_W-1:0] rd_rot;
    logic [2*DATA_W-1:0] wr_rot;
    logic [2*LANES-1:0]  en_rot;
    logic [DATA_W-1:0]   mask;
    logic [DATA_W-1:0]   observed;
    logic [DATA_W-1:0]   opnd;
    logic [DATA_W-1:0]   repl;
    logic                wr;
    logic                succ;

    assign shamt    = {i_lane, 3'b000};
    assign rd_rot   = {i_bank_data, i_bank_data} >> shamt;
    assign mask     = size_mask(i_size);
    assign observed = rd_rot[DATA_W-1:0] & mask;
    assign opnd     = i_operand & mask;

    always_comb begin
        repl = observed;
        wr   = 1'b0;
        succ = 1'b0;
        case (i_op)
            OP_LOAD: begin
                wr = 1'b0;
            end
            OP_STORE, OP_EXCHANGE: begin
                repl = opnd;
                wr   = 1'b1;
            end
            OP_CMPXCHG: begin
                succ = (observed == opnd);
                repl = i_desired & mask;
                wr   = succ;
            end
            OP_ADD: begin
                repl = (observed + opnd) & mask;
                wr   = 1'b1;
            end
            OP_AND: begin
                repl = observed & opnd;
                wr   = 1'b1;
            end
            OP_OR: begin
                repl = observed | opnd;
                wr   = 1'b1;
            end
            OP_XOR: begin
                repl = observed ^ opnd;
                wr   = 1'b1;
            end
            default: begin
                wr = 1'b0;
            end
        endcase
    end

    // rotate the result and the lane enables back onto the banks
    assign wr_rot = {repl, repl} << shamt;
    assign en_rot = {size_lanes(i_size), size_lanes(i_size)} << i_lane;

    always_comb begin
        o_res.wdata = wr_rot[2*DATA_W-1:DATA_W];
        o_res.wen   = (wr && i_ok) ? en_rot[2*LANES-1:LANES] : '0;
        o_res.success = succ && i_ok;
        if (!i_ok) begin
            o_res.old_value = '0;
        end else if (i_op == OP_STORE) begin
            o_res.old_value = i_operand;
        end else begin
            o_res.old_value = observed;
        end
    end

endmodule

>>> tb/sv/tb_atomic_memory_rmw_unit.sv
`timescale 1ns / 1ps
// self-checking testbench for atomic_memory_rmw_unit: a directed table, then random requests
// under several limit and write-enable settings, scored against a byte-level memory predictor
// depends on amru_pkg and the atomic_memory_rmw_unit rtl

module tb_atomic_memory_rmw_unit;
    import amru_pkg::*;

    localparam int MEM_BYTES   = 4096;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        t_op         op;
        logic [1:0]  size_code;
        logic [15:0] offs;
        logic [63:0] operand;
        logic [63:0] desired;
    } t_rmw_req;

    typedef struct {
        logic [63:0] old_value;
        logic        exchange_success;
        t_status     status;
    } t_rmw_res;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind          kind;
        t_rmw_req           rq;
        logic               fixed;
        t_rmw_res           res;
        t_cfg_idx           cfg_idx;
        logic [LIMIT_W-1:0] cfg_value;
    } t_stim_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // op, size_code, offset, operand_value, desired_value, zero fill
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // old_value, exchange_success, status, zero fill
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [LIMIT_W-1:0]     i_cfg_wdata = '0;

    logic [7:0]         mem_model [MEM_BYTES];
    logic [LIMIT_W-1:0] limit_reg = 13'd4096;
    logic               writable_reg = 1'b1;

    t_rmw_res  expected_results [$];
    t_stim_row stim_rows [$];

    int failures = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_cas_hits = 0;
    int n_err_status = 0;
    int cycle_count = 0;
    int burst_left = 0;

    int       rx_seg = 0;
    int       rx_hold = 0;
    int       rx_mode = 0;

    atomic_memory_rmw_unit #(
        .MEM_BYTES(MEM_BYTES)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int eff_limit();
        return (int'(limit_reg) > MEM_BYTES) ? MEM_BYTES : int'(limit_reg);
    endfunction

    function automatic logic [63:0] mask_of_width(int width);
        return (width >= 8) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << (width * 8)) - 64'd1);
    endfunction

    function automatic logic [63:0] read_le(int offset, int width);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < width; i++) begin
            v |= 64'(mem_model[offset + i]) << (8 * i);
        end
        return v;
    endfunction

    function automatic t_rmw_res predict_rmw(t_rmw_req rq);
        t_rmw_res    res;
        int          width;
        int          offset;
        logic [63:0] mask;
        logic [63:0] operand;
        logic [63:0] repl;
        logic        wr;
        width = 1 << rq.size_code;
        offset = int'(rq.offs);
        mask = mask_of_width(width);
        operand = rq.operand & mask;
        res = '{old_value: 64'd0, exchange_success: 1'b0, status: ST_OK};
        wr = 1'b1;
        if (offset + width > eff_limit()) begin
            res.status = ST_BOUNDS;
        end else if (rq.op != OP_LOAD && !writable_reg) begin
            res.status = ST_READONLY;
        end else begin
            res.old_value = read_le(offset, width) & mask;
            case (rq.op)
                OP_STORE, OP_EXCHANGE: repl = operand;
                OP_CMPXCHG: begin
                    res.exchange_success = (res.old_value == operand);
                    wr = res.exchange_success;
                    repl = rq.desired & mask;
                end
                OP_ADD:  repl = (res.old_value + operand) & mask;
                OP_AND:  repl = res.old_value & operand;
                OP_OR:   repl = res.old_value | operand;
                OP_XOR:  repl = res.old_value ^ operand;
                default: begin
                    repl = res.old_value;
                    wr = 1'b0;
                end
            endcase
            if (wr) begin
                for (int i = 0; i < width; i++) begin
                    mem_model[offset + i] = repl[8*i +: 8];
                end
            end
            if (rq.op == OP_STORE) begin
                res.old_value = rq.operand;
            end
        end
        return res;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_request(t_rmw_req rq);
        return {3'b000, rq.desired, rq.operand, rq.offs, rq.size_code, rq.op};
    endfunction

    function automatic t_rmw_req make_random_request();
        t_rmw_req rq;
        int       sel;
        int       bound;
        int       offset;
        int       width;
        bound = eff_limit();
        rq.op = t_op'($urandom_range(0, 7));
        rq.size_code = 2'($urandom_range(0, 3));
        width = 1 << rq.size_code;
        sel = $urandom_range(0, 99);
        if (sel < 65) begin
            offset = $urandom_range(0, 47);
        end else if (sel < 80) begin
            offset = (bound > 12) ? bound - int'($urandom_range(0, 12)) : $urandom_range(0, 16);
        end else if (sel < 92) begin
            offset = $urandom_range(0, MEM_BYTES - 1);
        end else begin
            offset = $urandom_range(0, 65535);
        end
        rq.offs = offset[15:0];
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
            rq.operand = {$urandom, $urandom};
        end else if (sel < 75) begin
            rq.operand = 64'($urandom_range(0, 255));
        end else if (sel < 88) begin
            rq.operand = 64'hFFFF_FFFF_FFFF_FFFF;
        end else begin
            rq.operand = '0;
        end
        rq.desired = {$urandom, $urandom};
        // steer about half of the in-store compare-exchanges onto the current contents
        if (rq.op == OP_CMPXCHG && offset + width <= MEM_BYTES && $urandom_range(0, 1) == 1) begin
            rq.operand = (read_le(offset, width) & mask_of_width(width))
                       | ({$urandom, $urandom} & ~mask_of_width(width));
        end
        return rq;
    endfunction

    function automatic void add_req(t_op op, logic [1:0] size_code, logic [15:0] offset,
                                    logic [63:0] operand, logic [63:0] desired, logic fixed,
                                    logic [63:0] old_value, logic success, t_status status);
        t_stim_row row;
        row.kind = ROW_REQ;
        row.rq = '{op: op, size_code: size_code, offs: offset,
                   operand: operand, desired: desired};
        row.fixed = fixed;
        row.res = '{old_value: old_value, exchange_success: success, status: status};
        row.cfg_idx = CFG_LIMIT;
        row.cfg_value = '0;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_cfg(t_cfg_idx idx, logic [LIMIT_W-1:0] value);
        t_stim_row row;
        row.kind = ROW_CFG;
        row.rq = '{op: OP_LOAD, size_code: 2'd0, offs: '0, operand: '0, desired: '0};
        row.fixed = 1'b0;
        row.res = '{old_value: 64'd0, exchange_success: 1'b0, status: ST_OK};
        row.cfg_idx = idx;
        row.cfg_value = value;
        stim_rows.push_back(row);
    endfunction

    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(0, 12);
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_request(t_rmw_req rq, logic fixed, t_rmw_res fixed_res);
        t_rmw_res res;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_request(rq);
        do @(posedge i_clk); while (!s_axis_tready);
        res = predict_rmw(rq);
        expected_results.push_back(fixed ? fixed_res : res);
        n_sent++;
        pace_sender();
    endtask

    task automatic wait_for_results();
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic set_register(t_cfg_idx idx, logic [LIMIT_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        wait_for_results();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_LIMIT) begin
            limit_reg = value;
        end else begin
            writable_reg = value[0];
        end
    endtask

    task automatic run_random_phase(int limit, logic writable, int count);
        t_rmw_res unused;
        unused = '{old_value: 64'd0, exchange_success: 1'b0, status: ST_OK};
        set_register(CFG_LIMIT, limit[LIMIT_W-1:0]);
        set_register(CFG_WRITABLE, {12'($urandom_range(0, 4095)), writable});
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) begin
                // hold off until the pipeline is empty
                s_axis_tvalid <= 1'b0;
                wait_for_results();
            end
            send_request(make_random_request(), 1'b0, unused);
        end
    endtask

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (rx_seg == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_seg  <= $urandom_range(20, 200);
        end else begin
            rx_seg <= rx_seg - 1;
        end
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            default: begin
                if (rx_hold != 0) begin
                    rx_hold <= rx_hold - 1;
                    m_axis_tready <= 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    rx_hold <= $urandom_range(1, 20);
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        endcase
    end

    // result scoreboard
    always @(posedge i_clk) begin
        t_rmw_res want;
        t_rmw_res got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.old_value        = m_axis_tdata[63:0];
            got.exchange_success = m_axis_tdata[64];
            got.status           = t_status'(m_axis_tdata[66:65]);
            if (got.status != ST_OK) n_err_status++;
            if (got.exchange_success) n_cas_hits++;
            if (expected_results.size() == 0) begin
                $error("unexpected result transfer: old_value %h", got.old_value);
                failures++;
            end else begin
                want = expected_results.pop_front();
                n_checked++;
                if (got.old_value !== want.old_value) begin
                    $error("old_value mismatch: expected %h, actual %h",
                           want.old_value, got.old_value);
                    failures++;
                end
                if (got.exchange_success !== want.exchange_success) begin
                    $error("exchange_success mismatch: expected %0d, actual %0d",
                           want.exchange_success, got.exchange_success);
                    failures++;
                end
                if (got.status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, got.status);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("atomic_memory_rmw_unit test failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < MEM_BYTES; i++) begin
            mem_model[i] = 8'h00;
        end

        add_req(OP_LOAD, 2'd3, 16'd0, '0, '0, 1'b1, 64'd0, 1'b0, ST_OK);
        add_req(OP_LOAD, 2'd0, 16'd4095, '0, '0, 1'b1, 64'd0, 1'b0, ST_OK);
        add_req(OP_LOAD, 2'd3, 16'd4089, '0, '0, 1'b1, 64'd0, 1'b0, ST_BOUNDS);
        add_req(OP_LOAD, 2'd3, 16'd4088, '0, '0, 1'b1, 64'd0, 1'b0, ST_OK);
        add_req(OP_STORE, 2'd3, 16'd0, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b1,
                64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ST_OK);
        add_req(OP_STORE, 2'd0, 16'd8, 64'h1234_5678_9ABC_DEF0, '0, 1'b1,
                64'h1234_5678_9ABC_DEF0, 1'b0, ST_OK);
        add_req(OP_LOAD, 2'd1, 16'd7, '0, '0, 1'b0, '0, 1'b0, ST_OK);
        add_req(OP_EXCHANGE, 2'd2, 16'd3, 64'hDEAD_BEEF_CAFE_BABE, '0, 1'b0, '0, 1'b0, ST_OK);
        add_req(OP_CMPXCHG, 2'd2, 16'd3, 64'h0000_0000_CAFE_BABE, 64'h1111_2222_3333_4444,
                1'b0, '0, 1'b0, ST_OK);
        add_req(OP_CMPXCHG, 2'd2, 16'd3, 64'h0000_0000_CAFE_BABE, 64'h1111_2222_3333_4444,
                1'b0, '0, 1'b0, ST_OK);
        add_req(OP_ADD, 2'd0, 16'd100, 64'h0000_0000_0000_00FF, '0, 1'b0, '0, 1'b0, ST_OK);
        add_req(OP_ADD, 2'd0, 16'd100, 64'h0000_0000_0000_0001, '0, 1'b0, '0, 1'b0, ST_OK);
        add_req(OP_ADD, 2'd3, 16'd200, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, '0, 1'b0, ST_OK);
        add_req(OP_ADD, 2'd3, 16'd200, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, '0, 1'b0, ST_OK);
        add_req(OP_AND, 2'd1, 16'd1, 64'h0000_0000_0000_0F0F, '0, 1'b0, '0, 1'b0, ST_OK);
        add_req(OP_OR, 2'd3, 16'd16, 64'hAAAA_AAAA_AAAA_AAAA, '0, 1'b0, '0, 1'b0, ST_OK);
        add_req(OP_XOR, 2'd3, 16'd16, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, '0, 1'b0, ST_OK);
        add_req(OP_LOAD, 2'd3, 16'd65535, '0, '0, 1'b1, 64'd0, 1'b0, ST_BOUNDS);
        add_req(OP_STORE, 2'd3, 16'd65528, 64'h5555_5555_5555_5555, '0, 1'b1,
                64'd0, 1'b0, ST_BOUNDS);
        add_req(OP_LOAD, 2'd3, 16'd0, '0, '0, 1'b0, '0, 1'b0, ST_OK);
        // read-only: loads still pass, everything else is refused
        add_cfg(CFG_WRITABLE, 13'h1FFE);
        add_req(OP_LOAD, 2'd0, 16'd8, '0, '0, 1'b0, '0, 1'b0, ST_OK);
        add_req(OP_STORE, 2'd0, 16'd0, 64'h0000_0000_0000_0042, '0, 1'b1,
                64'd0, 1'b0, ST_READONLY);
        add_req(OP_CMPXCHG, 2'd3, 16'd16, 64'h5555_5555_5555_5555, 64'h0123_4567_89AB_CDEF,
                1'b1, 64'd0, 1'b0, ST_READONLY);
        add_req(OP_STORE, 2'd3, 16'd4092, 64'h0000_0000_0000_0001, '0, 1'b1,
                64'd0, 1'b0, ST_BOUNDS);
        add_cfg(CFG_LIMIT, 13'd0);
        add_req(OP_LOAD, 2'd0, 16'd0, '0, '0, 1'b1, 64'd0, 1'b0, ST_BOUNDS);
        // limit above the store size clamps to the store
        add_cfg(CFG_LIMIT, 13'h1FFF);
        add_cfg(CFG_WRITABLE, 13'h0001);
        add_req(OP_EXCHANGE, 2'd3, 16'd4088, 64'h8000_0000_0000_0001, '0, 1'b0, '0, 1'b0, ST_OK);
        add_req(OP_LOAD, 2'd0, 16'd4096, '0, '0, 1'b1, 64'd0, 1'b0, ST_BOUNDS);
        add_cfg(CFG_LIMIT, 13'd4096);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_CFG) begin
                set_register(stim_rows[i].cfg_idx, stim_rows[i].cfg_value);
            end else begin
                send_request(stim_rows[i].rq, stim_rows[i].fixed, stim_rows[i].res);
            end
        end

        run_random_phase(4096, 1'b1, 400);
        run_random_phase(2048, 1'b1, 200);
        run_random_phase(4096, 1'b0, 150);
        run_random_phase(8191, 1'b1, 200);
        run_random_phase(37, 1'b1, 100);
        run_random_phase(0, 1'b1, 50);
        run_random_phase(4096, 1'b1, 200);

        s_axis_tvalid <= 1'b0;
        wait_for_results();
        repeat (8) @(posedge i_clk);

        $display("%0d requests sent, %0d results checked across seven limit/write settings",
                 n_sent, n_checked);
        $display("%0d compare-exchange hits, %0d bounds or read-only refusals",
                 n_cas_hits, n_err_status);
        if (failures == 0 && expected_results.size() == 0) begin
            $display("atomic_memory_rmw_unit test passed");
        end else begin
            $display("atomic_memory_rmw_unit test failed");
        end
        $finish;
    end

endmodule
